// File: rtl/sha1md_pkg.sv
// Shared types, constants and round helpers for the SHA-1 digest block.
`timescale 1ns / 1ps
package sha1md_pkg;

  localparam int WORD_W      = 32;
  localparam int BYTE_W      = 8;
  localparam int SCHED_DEPTH = 16;
  localparam int SCHED_AW    = $clog2(SCHED_DEPTH);
  localparam int NUM_VARS    = 5;

  // Byte position where the 64-bit length field starts.
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [5:0] BLOCK_LAST = 6'd63;
  // Round counter marks.
  localparam logic [6:0] ROUND_SCHED = 7'd16;
  localparam logic [6:0] ROUND_S1    = 7'd20;
  localparam logic [6:0] ROUND_S2    = 7'd40;
  localparam logic [6:0] ROUND_S3    = 7'd60;
  localparam logic [6:0] ROUND_LAST  = 7'd79;

  localparam logic [WORD_W-1:0] K0 = 32'h5A827999;
  localparam logic [WORD_W-1:0] K1 = 32'h6ED9EBA1;
  localparam logic [WORD_W-1:0] K2 = 32'h8F1BBCDC;
  localparam logic [WORD_W-1:0] K3 = 32'hCA62C1D6;

  localparam logic [WORD_W-1:0] IV_WORDS [NUM_VARS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  typedef enum logic [1:0] {
    STAGE_CH  = 2'd0,
    STAGE_P1  = 2'd1,
    STAGE_MAJ = 2'd2,
    STAGE_P2  = 2'd3
  } round_stage_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              has_byte;
    logic              end_of_message;
  } msg_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] digest_word;
    logic              last_word;
  } digest_item_t;

  // Control from the sequencer to the round core.
  typedef struct packed {
    logic         load;
    logic         step;
    round_stage_t stage;
  } round_ctrl_t;

  function automatic logic [WORD_W-1:0] round_k(round_stage_t stage);
    logic [WORD_W-1:0] k;
    case (stage)
      STAGE_CH:  k = K0;
      STAGE_P1:  k = K1;
      STAGE_MAJ: k = K2;
      STAGE_P2:  k = K3;
      default:   k = K0;
    endcase
    return k;
  endfunction

endpackage

// File: rtl/sha1md_sched_mem.sv
// Message schedule memory: 16 words, one write port, two registered read ports.
`timescale 1ns / 1ps
module sha1md_sched_mem (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [sha1md_pkg::SCHED_AW-1:0]      waddr,
  input  logic [sha1md_pkg::WORD_W-1:0]        wdata,
  input  logic [sha1md_pkg::SCHED_AW-1:0]      raddr0,
  input  logic [sha1md_pkg::SCHED_AW-1:0]      raddr1,
  output logic [sha1md_pkg::WORD_W-1:0]        rdata0,
  output logic [sha1md_pkg::WORD_W-1:0]        rdata1
);
  import sha1md_pkg::*;

  logic [WORD_W-1:0] mem [SCHED_DEPTH];

  // Write one word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read two words through registered outputs.
  always_ff @(posedge clk) begin
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// File: rtl/sha1md_round.sv
// SHA-1 round core: working variables a..e and one round per step.
`timescale 1ns / 1ps
module sha1md_round (
  input  logic                                        clk,
  input  sha1md_pkg::round_ctrl_t                     ctrl,
  input  logic [sha1md_pkg::WORD_W-1:0]               w,
  input  logic [sha1md_pkg::NUM_VARS-1:0][sha1md_pkg::WORD_W-1:0] init,
  output logic [sha1md_pkg::NUM_VARS-1:0][sha1md_pkg::WORD_W-1:0] vars
);
  import sha1md_pkg::*;

  logic [WORD_W-1:0] a, b, c, d, e;
  logic [WORD_W-1:0] f;
  logic [WORD_W-1:0] tmp;

  assign a = vars[0];
  assign b = vars[1];
  assign c = vars[2];
  assign d = vars[3];
  assign e = vars[4];

  // Pick the round function for this stage.
  always_comb begin
    case (ctrl.stage)
      STAGE_CH:  f = (b & c) | (~b & d);
      STAGE_MAJ: f = (b & c) | (b & d) | (c & d);
      default:   f = b ^ c ^ d;
    endcase
  end

  assign tmp = {a[26:0], a[31:27]} + f + e + w + round_k(ctrl.stage);

  // Load from the chaining value or advance one round.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      vars <= init;
    end else if (ctrl.step) begin
      vars[0] <= tmp;
      vars[1] <= a;
      vars[2] <= {b[1:0], b[31:2]};
      vars[3] <= c;
      vars[4] <= d;
    end
  end

endmodule

// File: rtl/sha1_message_digest.sv
// SHA-1 digest top level: byte loader, padding, round sequencer, digest output.
//
//   channel  | dir | payload        | handshake
//   ---------+-----+----------------+---------------------------
//   msg      | in  | msg_item_t     | msg_valid / msg_ready
//   digest   | out | digest_item_t  | digest_valid / digest_ready
//
// Message bytes are taken only while a block is loading. Each full 64-byte
// block is then compressed: a schedule read setup, the SHA-1 rounds, and a
// chaining add. Padding places one byte a cycle between compressions and
// pauses once, placing no byte, at the length field. Reset is synchronous and
// restores the initial vector. The five digest words wait in an output
// buffer; a new message loads while they drain, and the next digest waits
// for the buffer to empty.
`timescale 1ns / 1ps
module sha1_message_digest (
  input  logic                     clk,
  input  logic                     rst,
  input  sha1md_pkg::msg_item_t    msg,
  input  logic                     msg_valid,
  output logic                     msg_ready,
  output sha1md_pkg::digest_item_t digest,
  output logic                     digest_valid,
  input  logic                     digest_ready
);
  import sha1md_pkg::*;

  typedef enum logic [2:0] {
    S_FILL,
    S_PREP,
    S_ROUND,
    S_ADD,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    F_MSG,
    F_MARK,
    F_ZERO,
    F_LEN
  } fill_t;

  state_t                              state;
  fill_t                               fill;
  logic [5:0]                          pos;
  logic [23:0]                         acc;
  logic [63:0]                         bit_len;
  logic [6:0]                          rnd;
  logic [NUM_VARS-1:0][WORD_W-1:0]     chain;
  logic [NUM_VARS-1:0][WORD_W-1:0]     vars;
  logic [NUM_VARS-1:0][WORD_W-1:0]     out_buf;
  logic [2:0]                          out_cnt;

  logic                                put_en;
  logic [BYTE_W-1:0]                   put_byte;
  logic [BYTE_W-1:0]                   len_byte;
  logic                                msg_take;
  logic                                mem_we;
  logic [SCHED_AW-1:0]                 mem_waddr;
  logic [WORD_W-1:0]                   mem_wdata;
  logic [6:0]                          rd_round;
  logic [SCHED_AW-1:0]                 rd_base;
  logic [WORD_W-1:0]                   w_m3, w_m8, w_m14, w_cur;
  logic [WORD_W-1:0]                   w_mix;
  logic [WORD_W-1:0]                   w_round;
  round_ctrl_t                         rctrl;

  // Accept message items only while loading message bytes.
  assign msg_ready = (state == S_FILL) && (fill == F_MSG);
  assign msg_take  = msg_valid && msg_ready;

  // Length byte for the current tail position, big-endian.
  assign len_byte = 8'(bit_len >> {3'd7 - pos[2:0], 3'b000});

  // Select the byte placed this cycle.
  always_comb begin
    put_en   = 1'b0;
    put_byte = msg.data_byte;
    if (state == S_FILL) begin
      case (fill)
        F_MSG: begin
          put_en = msg_take && msg.has_byte;
        end
        F_MARK: begin
          put_en   = 1'b1;
          put_byte = 8'h80;
        end
        F_ZERO: begin
          put_en   = (pos != LEN_POS);
          put_byte = '0;
        end
        F_LEN: begin
          put_en   = 1'b1;
          put_byte = len_byte;
        end
        default: begin
          put_en = 1'b0;
        end
      endcase
    end
  end

  // Issue schedule reads one round ahead of the round core.
  assign rd_round = (state == S_PREP) ? '0 : rnd + 7'd1;
  assign rd_base  = rd_round[SCHED_AW-1:0];

  assign w_mix   = w_m3 ^ w_m8 ^ w_m14 ^ w_cur;
  assign w_round = (rnd < ROUND_SCHED) ? w_cur : {w_mix[30:0], w_mix[31]};

  // Write packed words while loading, schedule words while running rounds.
  always_comb begin
    if (state == S_ROUND) begin
      mem_we    = (rnd >= ROUND_SCHED);
      mem_waddr = rnd[SCHED_AW-1:0];
      mem_wdata = w_round;
    end else begin
      mem_we    = put_en && (pos[1:0] == 2'd3);
      mem_waddr = pos[5:2];
      mem_wdata = {acc, put_byte};
    end
  end

  sha1md_sched_mem u_mem_a (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wdata  (mem_wdata),
    .raddr0 (rd_base - SCHED_AW'(3)),
    .raddr1 (rd_base - SCHED_AW'(8)),
    .rdata0 (w_m3),
    .rdata1 (w_m8)
  );

  sha1md_sched_mem u_mem_b (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wdata  (mem_wdata),
    .raddr0 (rd_base - SCHED_AW'(14)),
    .raddr1 (rd_base),
    .rdata0 (w_m14),
    .rdata1 (w_cur)
  );

  // Drive the round core.
  always_comb begin
    rctrl.load = (state == S_PREP);
    rctrl.step = (state == S_ROUND);
    if (rnd < ROUND_S1) begin
      rctrl.stage = STAGE_CH;
    end else if (rnd < ROUND_S2) begin
      rctrl.stage = STAGE_P1;
    end else if (rnd < ROUND_S3) begin
      rctrl.stage = STAGE_MAJ;
    end else begin
      rctrl.stage = STAGE_P2;
    end
  end

  sha1md_round u_round (
    .clk  (clk),
    .ctrl (rctrl),
    .w    (w_round),
    .init (chain),
    .vars (vars)
  );

  assign digest_valid       = (out_cnt != '0);
  assign digest.digest_word = out_buf[0];
  assign digest.last_word   = (out_cnt == 3'd1);

  // Sequencer, chaining value and digest buffer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_FILL;
      fill    <= F_MSG;
      pos     <= '0;
      bit_len <= '0;
      rnd     <= '0;
      out_cnt <= '0;
      for (int i = 0; i < NUM_VARS; i++) begin
        chain[i] <= IV_WORDS[i];
      end
    end else begin
      // Drain the digest buffer.
      if (digest_valid && digest_ready) begin
        out_buf <= {WORD_W'(0), out_buf[NUM_VARS-1:1]};
        out_cnt <= out_cnt - 3'd1;
      end

      case (state)
        S_FILL: begin
          if (put_en) begin
            acc <= {acc[15:0], put_byte};
            pos <= pos + 6'd1;
            if (pos == BLOCK_LAST) begin
              state <= S_PREP;
            end
          end
          case (fill)
            F_MSG: begin
              if (msg_take) begin
                if (msg.has_byte) begin
                  bit_len <= bit_len + 64'd8;
                end
                if (msg.end_of_message) begin
                  fill <= F_MARK;
                end
              end
            end
            F_MARK: begin
              fill <= F_ZERO;
            end
            F_ZERO: begin
              if (pos == LEN_POS) begin
                fill <= F_LEN;
              end
            end
            default: begin
              fill <= fill;
            end
          endcase
        end
        S_PREP: begin
          rnd   <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          rnd <= rnd + 7'd1;
          if (rnd == ROUND_LAST) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          for (int i = 0; i < NUM_VARS; i++) begin
            chain[i] <= chain[i] + vars[i];
          end
          state <= (fill == F_LEN) ? S_DONE : S_FILL;
        end
        S_DONE: begin
          // Hand the digest over once the buffer is empty, then restart.
          if (out_cnt == '0) begin
            out_buf <= chain;
            out_cnt <= 3'(NUM_VARS);
            for (int i = 0; i < NUM_VARS; i++) begin
              chain[i] <= IV_WORDS[i];
            end
            bit_len <= '0;
            fill    <= F_MSG;
            state   <= S_FILL;
          end
        end
        default: begin
          state <= S_FILL;
        end
      endcase
    end
  end

  // A block always starts compression at a block boundary.
  a_prep_aligned: assert property (@(posedge clk) disable iff (rst)
    state == S_PREP |-> pos == '0)
    else $error("compression started off a block boundary");

  // The last round is followed by the chaining add.
  a_round_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && rnd == ROUND_LAST) |=> state == S_ADD)
    else $error("round sequence did not end in the chaining add");

  // The digest buffer never holds more than five words.
  a_out_bound: assert property (@(posedge clk) disable iff (rst)
    out_cnt <= 3'(NUM_VARS))
    else $error("digest buffer overfilled");

  // A digest is loaded only into an empty buffer.
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_cnt == '0) |=> out_cnt == 3'(NUM_VARS))
    else $error("digest load lost words");

endmodule

// File: tb/sha1_message_digest_test.sv
// Testbench for the SHA-1 message digest block: byte stimulus, digest prediction, checking.
`timescale 1ns / 1ps
module sha1_message_digest_test;
  import sha1md_pkg::*;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  msg_item_t    msg = '0;
  logic         msg_valid = 1'b0;
  logic         msg_ready;
  digest_item_t digest;
  logic         digest_valid;
  logic         digest_ready = 1'b0;

  // Idle rates in percent for each side
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  // Run statistics
  int fail_count = 0;
  int words_checked = 0;
  int messages_sent = 0;
  int bytes_sent = 0;
  int items_sent = 0;
  int ignored_items = 0;

  // Digest predictor state
  logic [31:0]  chain_h [5];
  logic [31:0]  sched [16];
  logic [63:0]  msg_bits;
  logic [5:0]   byte_pos;
  digest_item_t pending_digest_words [$];

  sha1_message_digest u_top (
    .clk          (clk),
    .rst          (rst),
    .msg          (msg),
    .msg_valid    (msg_valid),
    .msg_ready    (msg_ready),
    .digest       (digest),
    .digest_valid (digest_valid),
    .digest_ready (digest_ready)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [31:0] rotl(logic [31:0] x, int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  task automatic clear_digest_state();
    for (int i = 0; i < 5; i++) chain_h[i] = IV_WORDS[i];
    msg_bits = '0;
    byte_pos = '0;
  endtask

  // Run the 80 rounds over the current schedule and fold into the chain
  task automatic compress_block();
    logic [31:0] a, b, c, d, e, w, f, k, t;
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 16) begin
        w = sched[r];
      end else begin
        w = rotl(sched[(r - 3) & 15] ^ sched[(r - 8) & 15] ^ sched[(r - 14) & 15] ^
                 sched[r & 15], 1);
        sched[r & 15] = w;
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      t = rotl(a, 5) + f + e + w + k;
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endtask

  // Pack one byte big-endian into the block; compress on a full block
  task automatic absorb_byte(logic [7:0] value);
    int sh;
    sh = 8 * (3 - int'(byte_pos[1:0]));
    if (byte_pos[1:0] == 2'd0) sched[byte_pos[5:2]] = 32'(value) << sh;
    else sched[byte_pos[5:2]] = sched[byte_pos[5:2]] | (32'(value) << sh);
    byte_pos = byte_pos + 6'd1;
    if (byte_pos == 6'd0) compress_block();
  endtask

  // Advance the predictor by one accepted item; queue the digest on the last one
  task automatic predict_digest(msg_item_t item);
    logic [63:0]  len;
    digest_item_t word;
    if (item.has_byte) begin
      absorb_byte(item.data_byte);
      msg_bits += 64'd8;
    end
    if (item.end_of_message) begin
      len = msg_bits;
      absorb_byte(8'h80);
      while (byte_pos != LEN_POS) absorb_byte(8'h00);
      for (int i = 0; i < 8; i++) absorb_byte(len[63 - 8 * i -: 8]);
      for (int i = 0; i < 5; i++) begin
        word.digest_word = chain_h[i];
        word.last_word = (i == 4);
        pending_digest_words = {pending_digest_words, word};
      end
      clear_digest_state();
    end
  endtask

  // Send one transaction; called and returning at a falling edge
  task automatic send_item(msg_item_t item);
    while ($urandom_range(99) < sender_idle_pct) begin
      msg_valid <= 1'b0;
      @(negedge clk);
    end
    msg <= item;
    msg_valid <= 1'b1;
    do @(posedge clk); while (!msg_ready);
    predict_digest(item);
    if (item.has_byte || item.end_of_message) items_sent++;
    else ignored_items++;
    @(negedge clk);
  endtask

  // Send one message; fill below zero means random bytes
  task automatic send_message(int n_bytes, bit ends_on_byte, int fill, int noise_pct);
    msg_item_t item;
    for (int i = 0; i < n_bytes; i++) begin
      if ($urandom_range(99) < noise_pct) begin
        item.data_byte = 8'($urandom_range(255));
        item.has_byte = 1'b0;
        item.end_of_message = 1'b0;
        send_item(item);
      end
      item.data_byte = (fill < 0) ? 8'($urandom_range(255)) : 8'(fill);
      item.has_byte = 1'b1;
      item.end_of_message = ends_on_byte && (i == n_bytes - 1);
      send_item(item);
    end
    if (n_bytes == 0 || !ends_on_byte) begin
      item.data_byte = 8'($urandom_range(255));
      item.has_byte = 1'b0;
      item.end_of_message = 1'b1;
      send_item(item);
    end
    messages_sent++;
    bytes_sent += n_bytes;
  endtask

  task automatic test_empty_message();
    send_message(0, 1'b0, -1, 0);
  endtask

  task automatic test_byte_extremes();
    send_message(2, 1'b1, 8'h00, 0);
    send_message(2, 1'b0, 8'hFF, 0);
  endtask

  task automatic test_ignored_items();
    send_message(3, 1'b1, -1, 100);
    send_message(1, 1'b1, -1, 0);
  endtask

  // One lead message of a set length, then short messages with random content
  task automatic run_random_messages(int item_goal, int first_len);
    int start_items;
    int len;
    start_items = items_sent + ignored_items;
    send_message(first_len, 1'($urandom_range(1)), -1, 10);
    while (items_sent + ignored_items - start_items < item_goal) begin
      len = $urandom_range(12);
      send_message(len, 1'($urandom_range(1)), -1, 10);
    end
  endtask

  task automatic test_random_slow_sink();
    sender_idle_pct = 32;
    receiver_stall_pct = 59;
    run_random_messages(62, 56);
  endtask

  task automatic test_random_slow_source();
    sender_idle_pct = 59;
    receiver_stall_pct = 32;
    run_random_messages(16, 4);
  endtask

  task automatic test_random_full_rate();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    run_random_messages(16, 7);
  endtask

  // Stall the digest side at random
  always @(negedge clk) begin
    digest_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch on %s: expected %h, got %h", what, want, got);
  endtask

  // Compare each digest transaction with the oldest predicted word
  always @(posedge clk) begin : check_digest
    digest_item_t want;
    if (!rst && digest_valid && digest_ready) begin
      if (pending_digest_words.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected digest word %h (last %b)", digest.digest_word, digest.last_word);
      end else begin
        want = pending_digest_words.pop_front();
        words_checked++;
        if (digest.digest_word !== want.digest_word)
          note_mismatch("digest_word", want.digest_word, digest.digest_word);
        if (digest.last_word !== want.last_word)
          note_mismatch("last_word", 32'(want.last_word), 32'(digest.last_word));
      end
    end
  end

  initial begin
    clear_digest_state();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    sender_idle_pct = 32;
    receiver_stall_pct = 59;
    test_empty_message();
    test_byte_extremes();
    test_ignored_items();
    test_random_slow_sink();
    test_random_slow_source();
    test_random_full_rate();
    msg_valid <= 1'b0;

    // Drain outstanding digest words, then let the block settle
    while (pending_digest_words.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Checked %0d digest words over %0d messages (%0d bytes, %0d ignored items).",
             words_checked, messages_sent, bytes_sent, ignored_items);
    $display("Covered empty, byte-final and padding-edge messages under three idle mixes.");
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: sha1_message_digest.f
rtl/sha1md_pkg.sv
rtl/sha1md_sched_mem.sv
rtl/sha1md_round.sv
rtl/sha1_message_digest.sv
tb/sha1_message_digest_test.sv
